/* rtl/core/rgl_pkg.sv */
// Package: shared types, constants and helpers for the recursive Gaussian line pass
`default_nettype none
package rgl_pkg;

  localparam int POS_W      = 12;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 17;
  localparam int FB_W       = 26;
  localparam int NUM_CH     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [FB_W-1:0]   fb_t;
  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic [POS_W-1:0]         pos_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BWD_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_SEED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BWD_SEED     = 3'd5;

  localparam logic [1:0] MODE_ONE   = 2'd0;
  localparam logic [1:0] MODE_THREE = 2'd1;
  localparam logic [1:0] MODE_FOUR  = 2'd2;

  localparam logic [1:0] MODE_RESET     = MODE_FOUR;
  localparam coef_t      FWD_GAIN_RESET = 17'sd16384;
  localparam coef_t      BWD_GAIN_RESET = 17'sd16384;
  localparam coef_t      FB_GAIN_RESET  = -17'sd16384;
  localparam coef_t      FWD_SEED_RESET = 17'sd16384;
  localparam coef_t      BWD_SEED_RESET = 17'sd16384;

  typedef struct packed {
    logic step;
    logic start;
    logic act;
  } lane_ctl_t;

  typedef struct packed {
    logic act;
    fb_t  y;
  } lane_res_t;

  typedef struct packed {
    logic valid;
    pos_t position;
  } merge_ctl_t;

  typedef struct packed {
    pos_t position;
    pix_t ch3;
    pix_t ch2;
    pix_t ch1;
    pix_t ch0;
  } result_t;

  // Q.15 value to byte: negative -> 0, integer part limited to 255
  function automatic pix_t to_byte(input logic signed [27:0] v);
    if (v[27]) begin
      return '0;
    end else if (|v[27:23]) begin
      return '1;
    end else begin
      return v[22:15];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rgl_intf.sv */
// Interfaces: pixel input channel and filtered result channel
`default_nettype none
interface rgl_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  logic                pass_start;
  rgl_pkg::pos_t       position;
  rgl_pkg::pix_t       in_ch0;
  rgl_pkg::pix_t       in_ch1;
  rgl_pkg::pix_t       in_ch2;
  rgl_pkg::pix_t       in_ch3;

  modport source (
    output valid, action, pass_start, position, in_ch0, in_ch1, in_ch2, in_ch3,
    input  ready
  );
  modport sink (
    input  valid, action, pass_start, position, in_ch0, in_ch1, in_ch2, in_ch3,
    output ready
  );
endinterface

interface rgl_out_if;
  logic                valid;
  logic                ready;
  rgl_pkg::pos_t       out_position;
  rgl_pkg::pix_t       out_ch0;
  rgl_pkg::pix_t       out_ch1;
  rgl_pkg::pix_t       out_ch2;
  rgl_pkg::pix_t       out_ch3;

  modport source (
    output valid, out_position, out_ch0, out_ch1, out_ch2, out_ch3,
    input  ready
  );
  modport sink (
    input  valid, out_position, out_ch0, out_ch1, out_ch2, out_ch3,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/core/rgl_lane.sv */
// One channel lane: input products and the first-order feedback recursion
`default_nettype none
module rgl_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rgl_pkg::pix_t      x,
  input  wire rgl_pkg::coef_t     gain,
  input  wire rgl_pkg::coef_t     seed_gain,
  input  wire rgl_pkg::coef_t     fb_gain,
  input  wire rgl_pkg::lane_ctl_t ctl,
  output rgl_pkg::pix_t           store_byte,
  output rgl_pkg::lane_res_t      res_r
);

  typedef logic signed [42:0] prod_t;

  rgl_pkg::fb_t       xg_r;
  rgl_pkg::fb_t       xs_r;
  rgl_pkg::fb_t       fb_r;
  rgl_pkg::fb_t       xg_nxt;
  rgl_pkg::fb_t       xs_nxt;
  rgl_pkg::fb_t       fb_used;
  rgl_pkg::fb_t       y;
  prod_t              prod;
  logic signed [27:0] rnd;
  logic signed [28:0] diff;

  // Input products are taken one stage ahead of the feedback loop
  assign xg_nxt = rgl_pkg::fb_t'($signed({1'b0, x})) * rgl_pkg::fb_t'(gain);
  assign xs_nxt = rgl_pkg::fb_t'($signed({1'b0, x})) * rgl_pkg::fb_t'(seed_gain);

  assign fb_used = ctl.start ? xs_r : fb_r;
  assign prod    = prod_t'(fb_used) * prod_t'(fb_gain);
  assign rnd     = 28'((prod + prod_t'(16384)) >>> 15);
  assign diff    = 29'(xg_r) - 29'(rnd);

  always_comb begin
    if (diff[28:25] == {4{diff[25]}}) begin
      y = diff[25:0];
    end else if (diff[28]) begin
      y = {1'b1, {(rgl_pkg::FB_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(rgl_pkg::FB_W-1){1'b1}}};
    end
  end

  assign store_byte = ctl.act ? rgl_pkg::to_byte(28'(y)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else if (ctl.step) begin
      fb_r <= y;
    end
  end

  always_ff @(posedge clk) begin
    xg_r  <= xg_nxt;
    xs_r  <= xs_nxt;
    res_r <= '{act: ctl.act, y: y};
  end

endmodule
`default_nettype wire

/* rtl/core/rgl_line_store.sv */
// Line store: one write port, one registered read port with write bypass
`default_nettype none
module rgl_line_store #(
  parameter  int DEPTH = 4096,
  parameter  int WIDTH = 32,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= (we && wr_idx == rd_idx) ? wr_data : mem[rd_idx];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rgl_merge.sv */
// Merge stage: combines lane results with stored bytes and queues result transfers
`default_nettype none
module rgl_merge #(
  parameter int LANES = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rgl_pkg::merge_ctl_t                 ctl,
  input  wire rgl_pkg::lane_res_t                  res [LANES],
  input  wire logic [rgl_pkg::PIX_W*LANES-1:0]     prev,
  rgl_out_if.source                                out_if,
  output logic [rgl_pkg::FIFO_CNT_W-1:0]           cnt_r
);

  rgl_pkg::result_t                  fifo_mem [rgl_pkg::FIFO_DEPTH];
  logic [rgl_pkg::FIFO_PTR_W-1:0]    wp_r;
  logic [rgl_pkg::FIFO_PTR_W-1:0]    rp_r;
  logic [rgl_pkg::FIFO_CNT_W-1:0]    cnt_nxt;
  rgl_pkg::pix_t                     ch [rgl_pkg::NUM_CH];
  rgl_pkg::result_t                  head;
  logic                              push;
  logic                              pop;

  always_comb begin
    for (int c = 0; c < rgl_pkg::NUM_CH; c++) begin
      ch[c] = '0;
    end
    for (int c = 0; c < LANES; c++) begin
      if (res[c].act) begin
        ch[c] = rgl_pkg::to_byte(28'({prev[rgl_pkg::PIX_W*c +: rgl_pkg::PIX_W], 15'b0})
                                 + 28'(res[c].y));
      end
    end
  end

  assign push    = ctl.valid;
  assign pop     = out_if.valid & out_if.ready;
  assign cnt_nxt = cnt_r + rgl_pkg::FIFO_CNT_W'(push) - rgl_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wp_r] <= '{position: ctl.position, ch3: ch[3], ch2: ch[2],
                          ch1: ch[1], ch0: ch[0]};
    end
  end

  assign head                = fifo_mem[rp_r];
  assign out_if.valid        = (cnt_r != '0);
  assign out_if.out_position = head.position;
  assign out_if.out_ch0      = head.ch0;
  assign out_if.out_ch1      = head.ch1;
  assign out_if.out_ch2      = head.ch2;
  assign out_if.out_ch3      = head.ch3;

endmodule
`default_nettype wire

/* rtl/core/recursive_gaussian_line_pass_core.sv */
// Top level: recursive Gaussian line pass with per-channel lanes and a line store
//
// Input channel (in_if): one pixel per transfer. Forward items (action 0) run the
// causal recursion and write the clamped bytes to the line store at position;
// they give no result. Backward items (action 1) run the anticausal recursion and
// give one result on out_if: stored byte plus y, clamped, per active channel.
// pass_start seeds each lane's feedback from the pixel before the recursion.
// Config (cfg_we/cfg_index/cfg_data) must be written only while the block is idle;
// the block itself does not enforce this. Throughput: one item per cycle while
// in_if.ready is high, set by the lane feedback loop (one multiply, round and
// saturate per cycle in each lane). A backward result passes the address, product
// and feedback stages and then waits in an 8-entry result queue. in_if.ready
// counts results in flight plus queued ones, so a stalled receiver only stops
// input once the queue would fill; results already in the queue are held stable.
// Reset clears the feedback and restores the register defaults; the line store
// is not cleared and must be written by a forward pass before it is read.
`default_nettype none
module recursive_gaussian_line_pass_core #(
  parameter int MAX_LINE = 4096,
  parameter int LANES    = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rgl_in_if.sink                             in_if,
  rgl_out_if.source                          out_if,
  input  wire logic                          cfg_we,
  input  wire logic [rgl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rgl_pkg::COEF_W-1:0]    cfg_data
);

  localparam int IDX_W   = $clog2(MAX_LINE);
  localparam int STORE_W = rgl_pkg::PIX_W * LANES;
  localparam bit WRAP    = MAX_LINE < (2 ** rgl_pkg::POS_W);

  typedef logic [rgl_pkg::FIFO_CNT_W-1:0] cnt_t;

  logic [1:0]         mode_r;
  rgl_pkg::coef_t     fwd_gain_r;
  rgl_pkg::coef_t     bwd_gain_r;
  rgl_pkg::coef_t     fb_gain_r;
  rgl_pkg::coef_t     fwd_seed_r;
  rgl_pkg::coef_t     bwd_seed_r;

  logic [2:0]         n_active;
  logic [LANES-1:0]   lane_act;
  logic               accept;
  cnt_t               fifo_cnt;
  cnt_t               pending;
  rgl_pkg::pix_t      in_x [rgl_pkg::NUM_CH];

  logic               v0_r;
  logic               act0_r;
  logic               st0_r;
  rgl_pkg::pos_t      pos0_r;
  rgl_pkg::pix_t      x0_r [LANES];
  logic [IDX_W-1:0]   idx0;

  logic               v1_r;
  logic               act1_r;
  logic               st1_r;
  rgl_pkg::pos_t      pos1_r;
  logic [IDX_W-1:0]   idx1_r;

  logic               v2_r;
  rgl_pkg::pos_t      pos2_r;
  logic [STORE_W-1:0] prev2_r;

  rgl_pkg::coef_t     gain_sel;
  rgl_pkg::coef_t     seed_sel;
  rgl_pkg::lane_ctl_t lane_ctl [LANES];
  rgl_pkg::lane_res_t lane_res [LANES];
  logic [STORE_W-1:0] store_word;
  logic [STORE_W-1:0] rd_data;
  rgl_pkg::merge_ctl_t merge_ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= rgl_pkg::MODE_RESET;
      fwd_gain_r <= rgl_pkg::FWD_GAIN_RESET;
      bwd_gain_r <= rgl_pkg::BWD_GAIN_RESET;
      fb_gain_r  <= rgl_pkg::FB_GAIN_RESET;
      fwd_seed_r <= rgl_pkg::FWD_SEED_RESET;
      bwd_seed_r <= rgl_pkg::BWD_SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgl_pkg::CFG_CHANNEL_MODE: mode_r     <= cfg_data[1:0];
        rgl_pkg::CFG_FWD_GAIN:     fwd_gain_r <= cfg_data;
        rgl_pkg::CFG_BWD_GAIN:     bwd_gain_r <= cfg_data;
        rgl_pkg::CFG_FB_GAIN:      fb_gain_r  <= cfg_data;
        rgl_pkg::CFG_FWD_SEED:     fwd_seed_r <= cfg_data;
        rgl_pkg::CFG_BWD_SEED:     bwd_seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mode value 3 (reserved) runs as four channels, like MODE_FOUR
  always_comb begin
    unique case (mode_r)
      rgl_pkg::MODE_ONE:   n_active = 3'd1;
      rgl_pkg::MODE_THREE: n_active = 3'd3;
      default:             n_active = 3'd4;
    endcase
  end

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      lane_act[c] = (3'(c) < n_active);
    end
  end

  // Input side: ready reserves a queue entry for every result still in flight
  assign pending = fifo_cnt + cnt_t'(v0_r & act0_r) + cnt_t'(v1_r & act1_r) + cnt_t'(v2_r);
  assign in_if.ready = (pending < cnt_t'(rgl_pkg::FIFO_DEPTH));
  assign accept      = in_if.valid & in_if.ready;

  assign in_x[0] = in_if.in_ch0;
  assign in_x[1] = in_if.in_ch1;
  assign in_x[2] = in_if.in_ch2;
  assign in_x[3] = in_if.in_ch3;

  // Stage 0: capture transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act0_r <= in_if.action;
      st0_r  <= in_if.pass_start;
      pos0_r <= in_if.position;
      for (int c = 0; c < LANES; c++) begin
        x0_r[c] <= in_x[c];
      end
    end
  end

  // Store index: position modulo line length
  if (WRAP) begin : g_wrap
    localparam int SHIFT   = rgl_pkg::POS_W + $clog2(MAX_LINE);
    localparam int RECIP   = (2 ** SHIFT + MAX_LINE - 1) / MAX_LINE;
    localparam int RECIP_W = rgl_pkg::POS_W + 1;
    localparam int PROD_W  = rgl_pkg::POS_W + RECIP_W;
    typedef logic [PROD_W-1:0] qprod_t;

    qprod_t        qprod;
    rgl_pkg::pos_t quot_r;

    assign qprod = qprod_t'(in_if.position) * qprod_t'(RECIP);

    always_ff @(posedge clk) begin
      if (accept) begin
        quot_r <= rgl_pkg::pos_t'(qprod >> SHIFT);
      end
    end

    assign idx0 = IDX_W'(pos0_r - rgl_pkg::pos_t'(quot_r * rgl_pkg::pos_t'(MAX_LINE)));
  end else begin : g_flat
    assign idx0 = IDX_W'(pos0_r);
  end

  // Stage 1: products in lanes, store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
      v2_r <= v1_r & act1_r;
    end
  end

  always_ff @(posedge clk) begin
    act1_r  <= act0_r;
    st1_r   <= st0_r;
    pos1_r  <= pos0_r;
    idx1_r  <= idx0;
    pos2_r  <= pos1_r;
    prev2_r <= rd_data;
  end

  assign gain_sel = act0_r ? bwd_gain_r : fwd_gain_r;
  assign seed_sel = act0_r ? bwd_seed_r : fwd_seed_r;

  // Stage 2: feedback recursion in each lane
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    assign lane_ctl[c] = '{step: v1_r & lane_act[c], start: st1_r, act: lane_act[c]};

    rgl_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .x          (x0_r[c]),
      .gain       (gain_sel),
      .seed_gain  (seed_sel),
      .fb_gain    (fb_gain_r),
      .ctl        (lane_ctl[c]),
      .store_byte (store_word[rgl_pkg::PIX_W*c +: rgl_pkg::PIX_W]),
      .res_r      (lane_res[c])
    );
  end

  rgl_line_store #(
    .DEPTH (MAX_LINE),
    .WIDTH (STORE_W)
  ) u_store (
    .clk       (clk),
    .we        (v1_r & ~act1_r),
    .wr_idx    (idx1_r),
    .wr_data   (store_word),
    .re        (v0_r),
    .rd_idx    (idx0),
    .rd_data_r (rd_data)
  );

  // Stage 3: merge lanes and queue result
  assign merge_ctl = '{valid: v2_r, position: pos2_r};

  rgl_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (merge_ctl),
    .res    (lane_res),
    .prev   (prev2_r),
    .out_if (out_if),
    .cnt_r  (fifo_cnt)
  );

endmodule
`default_nettype wire
